// ===== src/b64e_pkg.sv =====
`timescale 1ns / 1ps

package b64e_pkg;

  // Queue between the front and back parts
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned MaxChars = 4;
  localparam int unsigned CharW    = 7;
  localparam int unsigned CharIdxW = $clog2(MaxChars);

  localparam logic [CharW-1:0] PadChar   = 7'h3D;  // '='
  localparam logic [CharW-1:0] PlusChar  = 7'h2B;  // '+'
  localparam logic [CharW-1:0] SlashChar = 7'h2F;  // '/'

  // Byte phase within a 3-byte group
  localparam logic [1:0] Phase0 = 2'd0;
  localparam logic [1:0] Phase1 = 2'd1;
  localparam logic [1:0] Phase2 = 2'd2;

  // One queue entry: every character one input byte produces
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CharIdxW-1:0]            last_idx;  // index of the final char of this byte
    logic                           fin;       // byte closes the message
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // 6-bit symbol to ASCII, standard alphabet
  function automatic logic [CharW-1:0] sym_char(input logic [5:0] v);
    logic [CharW-1:0] ext;
    logic [CharW-1:0] res;
    ext = {1'b0, v};
    if (v < 6'd26) begin
      res = ext + 7'd65;
    end else if (v < 6'd52) begin
      res = ext + 7'd71;
    end else if (v < 6'd62) begin
      res = ext - 7'd4;
    end else if (v == 6'd62) begin
      res = PlusChar;
    end else begin
      res = SlashChar;
    end
    return res;
  endfunction

endpackage

// ===== src/b64e_front.sv =====
`timescale 1ns / 1ps

// Takes a byte, tracks group phase and leftover bits, builds the char entry.
module b64e_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 final_byte_i,
  input  b64e_pkg::queue_stat_t stat_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output b64e_pkg::entry_t     entry_o
);

  logic [1:0] phase_q, phase_d;
  logic [5:0] left_q, left_d;
  logic [5:0] new_left;
  logic       accept;

  assign in_stall_o = stat_i.full;
  assign accept     = in_valid_i && !stat_i.full;
  assign push_o     = accept;

  always_comb begin
    entry_o.chars    = {b64e_pkg::MaxChars{b64e_pkg::PadChar}};
    entry_o.fin      = final_byte_i;
    entry_o.last_idx = '0;
    new_left         = '0;
    phase_d          = phase_q;
    case (phase_q)
      b64e_pkg::Phase1: begin
        new_left          = {data_byte_i[3:0], 2'b00};
        entry_o.chars[0]  = b64e_pkg::sym_char(left_q | {2'b00, data_byte_i[7:4]});
        entry_o.chars[1]  = b64e_pkg::sym_char(new_left);
        entry_o.last_idx  = final_byte_i ? 2'd2 : 2'd0;
        phase_d           = b64e_pkg::Phase2;
      end
      b64e_pkg::Phase2: begin
        new_left          = '0;
        entry_o.chars[0]  = b64e_pkg::sym_char(left_q | {4'b0000, data_byte_i[7:6]});
        entry_o.chars[1]  = b64e_pkg::sym_char(data_byte_i[5:0]);
        entry_o.last_idx  = 2'd1;
        phase_d           = b64e_pkg::Phase0;
      end
      default: begin  // phase 0, and the unreachable phase 3
        new_left          = {data_byte_i[1:0], 4'b0000};
        entry_o.chars[0]  = b64e_pkg::sym_char(data_byte_i[7:2]);
        entry_o.chars[1]  = b64e_pkg::sym_char(new_left);
        entry_o.last_idx  = final_byte_i ? 2'd3 : 2'd0;
        phase_d           = b64e_pkg::Phase1;
      end
    endcase
    left_d = new_left;
    if (final_byte_i) begin
      phase_d = b64e_pkg::Phase0;
      left_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64e_pkg::Phase0;
      left_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

// ===== src/b64e_queue.sv =====
`timescale 1ns / 1ps

// Small entry queue between front and back.
module b64e_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  b64e_pkg::entry_t      entry_i,
  input  logic                  pop_i,
  output b64e_pkg::entry_t      head_o,
  output b64e_pkg::queue_stat_t stat_o
);

  b64e_pkg::entry_t mem_q [b64e_pkg::QueueDepth];

  logic [b64e_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [b64e_pkg::QueueCntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == b64e_pkg::QueueCntW'(b64e_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == b64e_pkg::QueuePtrW'(b64e_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == b64e_pkg::QueuePtrW'(b64e_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/b64e_back.sv =====
`timescale 1ns / 1ps

// Walks the head entry into the output register one char per cycle when not stalled.
module b64e_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  b64e_pkg::entry_t      head_i,
  input  b64e_pkg::queue_stat_t stat_i,
  output logic                  pop_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [6:0]            out_char_o,
  output logic                  last_char_o
);

  logic [b64e_pkg::CharIdxW-1:0] idx_q;
  logic                          valid_q;
  logic [b64e_pkg::CharW-1:0]    char_q;
  logic                          last_q;
  logic                          load;
  logic                          at_end;

  assign load   = !stat_i.empty && (!valid_q || !out_stall_i);
  assign at_end = (idx_q == head_i.last_idx);
  assign pop_o  = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_end ? '0 : idx_q + 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.chars[idx_q];
      last_q <= head_i.fin && at_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

endmodule

// ===== src/base64_stream_encoder.sv =====
`timescale 1ns / 1ps

// Streaming base64 encoder, standard alphabet with '=' padding.
// Input channel: one raw byte per beat (data_byte_i) with final_byte_i set on
// the last byte of a message; accepted when in_valid_i is high and in_stall_o
// is low. Output channel: one ASCII char per beat (out_char_o), last_char_o
// set on the final char of the message; taken when out_valid_o is high and
// out_stall_i is low.
// A byte yields one or two chars; a final byte adds the partial char and
// padding, up to four chars in all.
// A taken byte is written into the queue, then loaded into the output register
// as its first char. The output register moves one char per cycle while the
// queue holds an entry and out_stall_i is low.
// The front accepts a byte per cycle while the 2-entry queue has room.
// Reset (async, active low) clears phase, leftover bits, queue and the output
// valid. When the receiver stalls, the output char holds, the queue fills and
// in_stall_o rises; nothing is dropped.
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] out_char_o,
  output logic       last_char_o
);

  b64e_pkg::entry_t      push_entry;
  b64e_pkg::entry_t      head_entry;
  b64e_pkg::queue_stat_t q_stat;
  logic                  push;
  logic                  pop;

  // Front: phase tracking and symbol lookup, one entry per byte
  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .stat_i       (q_stat),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Decouples byte acceptance from char emission
  b64e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .stat_o  (q_stat)
  );

  // Back: serializes chars into the output register
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .stat_i      (q_stat),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// ===== src/b64e_checker.sv =====
`timescale 1ns / 1ps

module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] out_char_o,
  input logic       last_char_o
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o) &&
    $stable(last_char_o))
    else $error("output beat changed under stall");

  // Every char is from the alphabet or padding
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_char_o >= 7'd65 && out_char_o <= 7'd90) ||
                     (out_char_o >= 7'd97 && out_char_o <= 7'd122) ||
                     (out_char_o >= 7'd48 && out_char_o <= 7'd57) ||
                     out_char_o == 7'd43 || out_char_o == 7'd47 ||
                     out_char_o == 7'd61))
    else $error("illegal output char");

  // Padding is never followed by a non-padding char within a message
  a_pad_then_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_char_o == 7'd61 && !last_char_o
    |=> !out_valid_o || out_char_o == 7'd61)
    else $error("data char after padding");

  // Leaving reset: nothing pending, input open
  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("state not clear after reset");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_char_o  (out_char_o),
  .last_char_o (last_char_o)
);
